// ----- rtl/core/sac_pkg.sv -----
// Shared types and constants of the set-associative cache tag model.
package sac_pkg;

  localparam int COUNT_W = 32;
  localparam int RANK_W = 3;
  localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_INDEX_W-1:0] CFG_SET_BITS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WAY_COUNT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_BITS = 2'd2;

  localparam logic [1:0] OP_ACCESS = 2'd0;
  localparam logic [1:0] OP_MODIFY = 2'd1;
  localparam logic [1:0] OP_FETCH = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] address;
  } in_t;

  typedef struct packed {
    logic               was_hit;
    logic               was_eviction;
    logic [COUNT_W-1:0] hit_total;
    logic [COUNT_W-1:0] miss_total;
    logic [COUNT_W-1:0] eviction_total;
    logic               last_result;
  } out_t;

endpackage

// ----- rtl/core/sac_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
module sac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/set_assoc_cache_lru_sim_top.sv -----
// Tag side of a set-associative cache with LRU replacement, driven by an access trace.
//
// The input channel takes one transaction per trace record: an op code and a
// byte address. A load or store gives one result, a modify gives two results
// for the same address, and an instruction fetch or unused op gives none.
// Each result carries hit and eviction flags, the three saturating running
// totals, and last_result on the final result of its transaction.
// The configuration channel sets the set index bits, the ways in use and the
// block offset bits; it is always ready. It is to be written while the block is
// idle; the user is bound to this, as the block itself does not enforce it.
// Each access is a read-modify-write of one set row in a single RAM, and a
// modify does this twice. The result is registered when its row is written back.
// After reset a clearing pass writes every set row (2^MAX_SET_BITS rows, 256 by
// default), during which no input transaction is accepted.
// The result register holds one result; while the receiver stalls, a new
// input transaction is still accepted and its access waits until it is free.
module set_assoc_cache_lru_sim_top import sac_pkg::*; #(
  parameter int MAX_SET_BITS = 8,
  parameter int MAX_WAYS = 8,
  parameter int ADDRESS_WIDTH = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_t                    in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_t                   out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int ROWS = 1 << MAX_SET_BITS;
  localparam int TAG_W = ADDRESS_WIDTH - 2;
  localparam int WAY_W = 1 + RANK_W + TAG_W;
  localparam int ROW_W = MAX_WAYS * WAY_W;
  localparam int WAYC_W = $clog2(MAX_WAYS + 1);
  localparam int WIDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int SH_W = $clog2(MAX_SET_BITS + 32 + 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_LOOK = 2'd2;
  localparam logic [1:0] S_NEXT = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic [MAX_SET_BITS-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [MAX_SET_BITS-1:0] set_r, set_nxt;
  logic [TAG_W-1:0]        tag_r, tag_nxt;
  logic                    modify_r, modify_nxt;
  logic                    pass_r, pass_nxt;
  logic [COUNT_W-1:0]      hit_cnt_r, hit_cnt_nxt;
  logic [COUNT_W-1:0]      miss_cnt_r, miss_cnt_nxt;
  logic [COUNT_W-1:0]      evict_cnt_r, evict_cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_t                    out_r, out_nxt;
  logic [3:0]              set_bits_r;
  logic [3:0]              way_count_r;
  logic [5:0]              block_bits_r;

  logic [SH_W-1:0]          set_c, blk_c, tag_sh;
  logic [WAYC_W-1:0]        ways_c;
  logic [ADDRESS_WIDTH-1:0] addr_m;
  logic [MAX_SET_BITS-1:0]  set_mask, in_set;
  logic [TAG_W-1:0]         in_tag;

  logic                    ram_we, ram_re;
  logic [MAX_SET_BITS-1:0] ram_waddr, ram_raddr;
  logic [ROW_W-1:0]        ram_wdata, rd_row, new_row;

  logic                    v_q [MAX_WAYS];
  logic [RANK_W-1:0]       rank_q [MAX_WAYS];
  logic [TAG_W-1:0]        tag_q [MAX_WAYS];
  logic                    acc_hit, acc_evict;
  logic                    can_load;

  assign cfg_ready = 1'b1;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_r;
  assign can_load = !out_valid_r || out_ready;

  always_comb begin
    if (set_bits_r == 4'd0) begin
      set_c = SH_W'(1);
    end else if (32'(set_bits_r) > MAX_SET_BITS) begin
      set_c = SH_W'(MAX_SET_BITS);
    end else begin
      set_c = SH_W'(set_bits_r);
    end
    if (block_bits_r == 6'd0) begin
      blk_c = SH_W'(1);
    end else if (block_bits_r > 6'd32) begin
      blk_c = SH_W'(32);
    end else begin
      blk_c = SH_W'(block_bits_r);
    end
    if (way_count_r == 4'd0) begin
      ways_c = WAYC_W'(1);
    end else if (32'(way_count_r) > MAX_WAYS) begin
      ways_c = WAYC_W'(MAX_WAYS);
    end else begin
      ways_c = WAYC_W'(way_count_r);
    end
  end

  always_comb begin
    addr_m = in_data.address[ADDRESS_WIDTH-1:0];
    tag_sh = blk_c + set_c;
    for (int i = 0; i < MAX_SET_BITS; i++) begin
      set_mask[i] = (i < int'(set_c));
    end
    in_set = MAX_SET_BITS'(addr_m >> blk_c) & set_mask;
    in_tag = TAG_W'(addr_m >> tag_sh);
  end

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      v_q[w] = rd_row[w*WAY_W + TAG_W + RANK_W];
      rank_q[w] = rd_row[w*WAY_W + TAG_W +: RANK_W];
      tag_q[w] = rd_row[w*WAY_W +: TAG_W];
    end
  end

  always_comb begin
    logic              have_fill;
    logic              was_valid;
    logic [WIDX_W-1:0] hit_way, fill_way, vict, sel;
    logic [RANK_W-1:0] vict_rank, sel_rank;
    logic              nv;
    logic [RANK_W-1:0] nr;
    logic [TAG_W-1:0]  nt;
    acc_hit = 1'b0;
    have_fill = 1'b0;
    hit_way = '0;
    fill_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (w < int'(ways_c) && v_q[w] && tag_q[w] == tag_r) begin
        acc_hit = 1'b1;
        hit_way = WIDX_W'(w);
      end
      if (w < int'(ways_c) && !v_q[w]) begin
        have_fill = 1'b1;
        fill_way = WIDX_W'(w);
      end
    end
    vict = '0;
    vict_rank = rank_q[0];
    for (int v = 1; v < MAX_WAYS; v++) begin
      if (v < int'(ways_c) && rank_q[v] > vict_rank) begin
        vict = WIDX_W'(v);
        vict_rank = rank_q[v];
      end
    end
    if (acc_hit) begin
      sel = hit_way;
    end else if (have_fill) begin
      sel = fill_way;
    end else begin
      sel = vict;
    end
    was_valid = acc_hit || !have_fill;
    acc_evict = !acc_hit && !have_fill;
    sel_rank = rank_q[sel];
    new_row = '0;
    for (int v = 0; v < MAX_WAYS; v++) begin
      nv = v_q[v];
      nr = rank_q[v];
      nt = tag_q[v];
      if (v == int'(sel)) begin
        nr = '0;
        if (!acc_hit) begin
          nv = 1'b1;
          nt = tag_r;
        end
      end else if (v < int'(ways_c) && v_q[v] && (!was_valid || rank_q[v] < sel_rank)
                   && rank_q[v] != RANK_MAX) begin
        nr = rank_q[v] + 1'b1;
      end
      new_row[v*WAY_W +: WAY_W] = {nv, nr, nt};
    end
  end

  always_comb begin
    state_nxt = state_r;
    clr_cnt_nxt = clr_cnt_r;
    set_nxt = set_r;
    tag_nxt = tag_r;
    modify_nxt = modify_r;
    pass_nxt = pass_r;
    hit_cnt_nxt = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    evict_cnt_nxt = evict_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt = out_r;
    ram_we = 1'b0;
    ram_waddr = set_r;
    ram_wdata = new_row;
    ram_re = 1'b0;
    ram_raddr = set_r;
    case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && (in_data.op == OP_ACCESS || in_data.op == OP_MODIFY)) begin
          ram_re = 1'b1;
          ram_raddr = in_set;
          set_nxt = in_set;
          tag_nxt = in_tag;
          modify_nxt = (in_data.op == OP_MODIFY);
          pass_nxt = 1'b0;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (can_load) begin
          ram_we = 1'b1;
          if (acc_hit) begin
            hit_cnt_nxt = (hit_cnt_r == '1) ? hit_cnt_r : hit_cnt_r + 1'b1;
          end else begin
            miss_cnt_nxt = (miss_cnt_r == '1) ? miss_cnt_r : miss_cnt_r + 1'b1;
          end
          if (acc_evict) begin
            evict_cnt_nxt = (evict_cnt_r == '1) ? evict_cnt_r : evict_cnt_r + 1'b1;
          end
          out_valid_nxt = 1'b1;
          out_nxt.was_hit = acc_hit;
          out_nxt.was_eviction = acc_evict;
          out_nxt.hit_total = hit_cnt_nxt;
          out_nxt.miss_total = miss_cnt_nxt;
          out_nxt.eviction_total = evict_cnt_nxt;
          out_nxt.last_result = !modify_r || pass_r;
          if (modify_r && !pass_r) begin
            pass_nxt = 1'b1;
            state_nxt = S_NEXT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_NEXT: begin
        ram_re = 1'b1;
        state_nxt = S_LOOK;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_cnt_r <= '0;
      modify_r <= 1'b0;
      pass_r <= 1'b0;
      hit_cnt_r <= '0;
      miss_cnt_r <= '0;
      evict_cnt_r <= '0;
      out_valid_r <= 1'b0;
      set_bits_r <= 4'd1;
      way_count_r <= 4'd1;
      block_bits_r <= 6'd4;
    end else begin
      state_r <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      modify_r <= modify_nxt;
      pass_r <= pass_nxt;
      hit_cnt_r <= hit_cnt_nxt;
      miss_cnt_r <= miss_cnt_nxt;
      evict_cnt_r <= evict_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SET_BITS: set_bits_r <= cfg_data[3:0];
          CFG_WAY_COUNT: way_count_r <= cfg_data[3:0];
          CFG_BLOCK_BITS: block_bits_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    set_r <= set_nxt;
    tag_r <= tag_nxt;
    out_r <= out_nxt;
  end

  sac_ram #(
    .WIDTH(ROW_W),
    .DEPTH(ROWS)
  ) u_row_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(rd_row)
  );

  a_no_hit_and_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.was_hit && out_r.was_eviction))
    else $error("Result flags both a hit and an eviction.");

  a_stall_holds_access: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK && out_valid_r && !out_ready) |=> state_r == S_LOOK)
    else $error("Access left the lookup state while the result register was full.");

  a_hits_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> hit_cnt_r >= $past(hit_cnt_r))
    else $error("Hit total decreased.");

  a_write_only_when_owned: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLEAR || (state_r == S_LOOK && can_load)))
    else $error("Row RAM written outside a clear or a completed lookup.");

endmodule

// ----- test/sac_trace_checker.sv -----
// Checker that predicts the cache tag results from the observed transactions and compares them.
module sac_trace_checker import sac_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  in_t                    in_data,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  out_t                   out_data,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     outstanding,
  output int                     mismatches,
  output int                     results_checked,
  output int                     hits_seen,
  output int                     evictions_seen
);

  localparam int MAX_SET_BITS = 8;
  localparam int MAX_WAYS = 8;
  localparam int LINE_COUNT = (1 << MAX_SET_BITS) * MAX_WAYS;

  bit                 line_ok   [LINE_COUNT];
  logic [63:0]        line_tag  [LINE_COUNT];
  logic [RANK_W-1:0]  line_rank [LINE_COUNT];
  logic [COUNT_W-1:0] hit_cnt;
  logic [COUNT_W-1:0] miss_cnt;
  logic [COUNT_W-1:0] evict_cnt;
  logic [3:0]         set_bits_q;
  logic [3:0]         way_count_q;
  logic [5:0]         block_bits_q;

  out_t due_results [$];
  int   fail_cnt = 0;
  int   checked_cnt = 0;
  int   hit_obs = 0;
  int   evict_obs = 0;

  function automatic void promote_way(int base, int ways, int w, bit was_valid);
    logic [RANK_W-1:0] r;
    r = line_rank[base + w];
    for (int v = 0; v < ways; v++) begin
      if (v != w && line_ok[base + v] && (!was_valid || line_rank[base + v] < r) &&
          line_rank[base + v] != RANK_MAX) begin
        line_rank[base + v] = line_rank[base + v] + 1'b1;
      end
    end
    line_rank[base + w] = '0;
  endfunction

  function automatic out_t cache_access(input logic [63:0] addr);
    int          s;
    int          ways;
    int          b;
    int          base;
    int          hit_way;
    int          free_way;
    int          victim;
    logic [63:0] set_idx;
    logic [63:0] tag;
    out_t        res;
    s = (set_bits_q == 0) ? 1 : (set_bits_q > MAX_SET_BITS) ? MAX_SET_BITS : set_bits_q;
    ways = (way_count_q == 0) ? 1 : (way_count_q > MAX_WAYS) ? MAX_WAYS : way_count_q;
    b = (block_bits_q == 0) ? 1 : (block_bits_q > 32) ? 32 : block_bits_q;
    set_idx = (addr >> b) & ((64'd1 << s) - 64'd1);
    tag = addr >> (s + b);
    base = int'(set_idx) * MAX_WAYS;
    res = '0;
    hit_way = -1;
    for (int v = ways - 1; v >= 0; v--) begin
      if (line_ok[base + v] && line_tag[base + v] == tag) hit_way = v;
    end
    if (hit_way >= 0) begin
      res.was_hit = 1'b1;
      if (hit_cnt != '1) hit_cnt = hit_cnt + 1'b1;
      promote_way(base, ways, hit_way, 1'b1);
    end else begin
      if (miss_cnt != '1) miss_cnt = miss_cnt + 1'b1;
      free_way = ways;
      for (int v = ways - 1; v >= 0; v--) begin
        if (!line_ok[base + v]) free_way = v;
      end
      if (free_way < ways) begin
        promote_way(base, ways, free_way, 1'b0);
        line_ok[base + free_way] = 1'b1;
        line_tag[base + free_way] = tag;
      end else begin
        victim = 0;
        for (int v = 1; v < ways; v++) begin
          if (line_rank[base + v] > line_rank[base + victim]) victim = v;
        end
        res.was_eviction = 1'b1;
        if (evict_cnt != '1) evict_cnt = evict_cnt + 1'b1;
        promote_way(base, ways, victim, 1'b1);
        line_tag[base + victim] = tag;
      end
    end
    res.hit_total = hit_cnt;
    res.miss_total = miss_cnt;
    res.eviction_total = evict_cnt;
    return res;
  endfunction

  always @(posedge clk) begin
    out_t r;
    out_t want;
    if (!rst_n) begin
      for (int i = 0; i < LINE_COUNT; i++) begin
        line_ok[i] = 1'b0;
        line_tag[i] = '0;
        line_rank[i] = '0;
      end
      hit_cnt = '0;
      miss_cnt = '0;
      evict_cnt = '0;
      set_bits_q = 4'd1;
      way_count_q = 4'd1;
      block_bits_q = 6'd4;
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SET_BITS:   set_bits_q = cfg_data[3:0];
          CFG_WAY_COUNT:  way_count_q = cfg_data[3:0];
          CFG_BLOCK_BITS: block_bits_q = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (in_data.op)
          OP_ACCESS: begin
            r = cache_access(in_data.address);
            r.last_result = 1'b1;
            due_results.push_back(r);
          end
          OP_MODIFY: begin
            r = cache_access(in_data.address);
            due_results.push_back(r);
            r = cache_access(in_data.address);
            r.last_result = 1'b1;
            due_results.push_back(r);
          end
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("Unexpected result with nothing outstanding: hit=%0b evict=%0b hits=%0d",
                     out_data.was_hit, out_data.was_eviction, out_data.hit_total);
          end
        end else begin
          want = due_results.pop_front();
          checked_cnt++;
          if (out_data.was_hit === 1'b1) hit_obs++;
          if (out_data.was_eviction === 1'b1) evict_obs++;
          if (out_data !== want) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
              $display({"Mismatch on result %0d: expected hit=%0b evict=%0b hits=%0d ",
                        "misses=%0d evictions=%0d last=%0b, got hit=%0b evict=%0b hits=%0d ",
                        "misses=%0d evictions=%0d last=%0b"},
                       checked_cnt, want.was_hit, want.was_eviction, want.hit_total,
                       want.miss_total, want.eviction_total, want.last_result,
                       out_data.was_hit, out_data.was_eviction, out_data.hit_total,
                       out_data.miss_total, out_data.eviction_total, out_data.last_result);
            end
          end
        end
      end
    end
    outstanding <= due_results.size();
    mismatches <= fail_cnt;
    results_checked <= checked_cnt;
    hits_seen <= hit_obs;
    evictions_seen <= evict_obs;
  end

endmodule

// ----- test/tb.sv -----
// Testbench top that drives access traces and register settings into the cache tag model.
module tb;
  import sac_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 160;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [PHASES*6-1:0] PHASE_SET_BITS =
    {6'd1, 6'd8, 6'd0, 6'd63, 6'd2, 6'd3, 6'd1, 6'd5, 6'd16, 6'd4};
  localparam logic [PHASES*6-1:0] PHASE_WAYS =
    {6'd1, 6'd8, 6'd0, 6'd63, 6'd4, 6'd2, 6'd8, 6'd3, 6'd9, 6'd7};
  localparam logic [PHASES*6-1:0] PHASE_BLOCK_BITS =
    {6'd1, 6'd32, 6'd0, 6'd63, 6'd6, 6'd12, 6'd4, 6'd33, 6'd20, 6'd2};

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_t                    in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_t                   out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int outstanding;
  int mismatches;
  int results_checked;
  int hits_seen;
  int evictions_seen;

  int send_idle_pct = 34;
  int recv_idle_pct = 55;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;
  int records_sent = 0;
  int settings_used = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  set_assoc_cache_lru_sim_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  sac_trace_checker checker_inst (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .outstanding(outstanding),
    .mismatches(mismatches),
    .results_checked(results_checked),
    .hits_seen(hits_seen),
    .evictions_seen(evictions_seen)
  );

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_request = 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, outstanding);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_record(input logic [1:0] op, input logic [63:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {op, addr};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    records_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [5:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic [5:0] sb, input logic [5:0] wc, input logic [5:0] bb);
    write_reg(CFG_SET_BITS, sb);
    write_reg(CFG_WAY_COUNT, wc);
    write_reg(CFG_BLOCK_BITS, bb);
    write_reg(CFG_UNUSED, 6'($urandom));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int          s_eff;
    int          w_eff;
    int          b_eff;
    int          roll;
    int          set_span;
    logic [5:0]  raw;
    logic [63:0] tag_pool [10];
    logic [63:0] set_idx;
    logic [63:0] addr;
    logic [1:0]  op;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    settings_used = 1;

    send_record(OP_ACCESS, 64'h0);
    send_record(OP_ACCESS, 64'h8);
    send_record(OP_MODIFY, 64'h20);
    send_record(OP_FETCH, 64'h0);
    send_record(OP_UNUSED, '1);
    send_record(OP_ACCESS, '1);
    send_record(OP_MODIFY, '1);
    send_record(OP_ACCESS, 64'h8000_0000_0000_0000);

    drain();
    configure(6'd8, 6'd8, 6'd32);
    for (int t = 0; t < 9; t++) begin
      send_record(OP_ACCESS, (64'(t) << 40) | (64'd255 << 32));
    end
    send_record(OP_ACCESS, (64'd1 << 40) | (64'd255 << 32));
    send_record(OP_ACCESS, 64'd255 << 32);

    // Leave the same tag in two ways, then widen again so both ways match.
    drain();
    configure(6'd1, 6'd2, 6'd4);
    send_record(OP_ACCESS, 64'h0);
    send_record(OP_ACCESS, 64'h8000_0000_0000_0000);
    drain();
    configure(6'd1, 6'd1, 6'd4);
    send_record(OP_ACCESS, 64'h8000_0000_0000_0000);
    drain();
    configure(6'd1, 6'd2, 6'd4);
    send_record(OP_ACCESS, 64'h8000_0000_0000_0000);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      if (p < 4) begin
        send_idle_pct = 34;
        recv_idle_pct = 55;
      end else if (p < 7) begin
        send_idle_pct = 55;
        recv_idle_pct = 34;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      configure(PHASE_SET_BITS[(PHASES-1-p)*6 +: 6], PHASE_WAYS[(PHASES-1-p)*6 +: 6],
                PHASE_BLOCK_BITS[(PHASES-1-p)*6 +: 6]);
      raw = PHASE_SET_BITS[(PHASES-1-p)*6 +: 6];
      s_eff = (raw[3:0] == 0) ? 1 : (raw[3:0] > 8) ? 8 : raw[3:0];
      raw = PHASE_WAYS[(PHASES-1-p)*6 +: 6];
      w_eff = (raw[3:0] == 0) ? 1 : (raw[3:0] > 8) ? 8 : raw[3:0];
      raw = PHASE_BLOCK_BITS[(PHASES-1-p)*6 +: 6];
      b_eff = (raw == 0) ? 1 : (raw > 32) ? 32 : raw;
      set_span = (s_eff > 2) ? 4 : (1 << s_eff);
      for (int i = 0; i < 10; i++) begin
        tag_pool[i] = i[0] ? {$urandom, $urandom} : 64'(i);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ((p == 1 || p == 5) && n == 40) hold_request = 1'b1;
        roll = $urandom_range(99);
        op = (roll < 45) ? OP_ACCESS : (roll < 85) ? OP_MODIFY :
             (roll < 95) ? OP_FETCH : OP_UNUSED;
        if ($urandom_range(99) < 8) begin
          addr = {$urandom, $urandom};
        end else begin
          set_idx = ($urandom_range(9) == 0) ? 64'($urandom_range((1 << s_eff) - 1)) :
                                                64'($urandom_range(set_span - 1));
          addr = (tag_pool[$urandom_range(w_eff + 1)] << (s_eff + b_eff)) |
                 (set_idx << b_eff) |
                 ({$urandom, $urandom} & ((64'd1 << b_eff) - 64'd1));
        end
        send_record(op, addr);
      end
    end

    drain();
    $display("Ran %0d trace records under %0d cache settings, clamped register values included.",
             records_sent, settings_used);
    $display("Checked %0d results, of which %0d were hits and %0d evictions.",
             results_checked, hits_seen, evictions_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- set_assoc_cache_lru_sim_top.f -----
rtl/core/sac_pkg.sv
rtl/core/sac_ram.sv
rtl/core/set_assoc_cache_lru_sim_top.sv
test/sac_trace_checker.sv
test/tb.sv
